### design/rd_pkg.sv
// Package for the rectangle difference unit.
// Holds the coordinate width, queue sizing and the job record shared by all modules.
// No dependencies.
package rd_pkg;

  localparam int COORD_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int PART_LEFT   = 0;
  localparam int PART_RIGHT  = 1;
  localparam int PART_BOTTOM = 2;
  localparam int PART_TOP    = 3;
  localparam int NUM_PARTS   = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t xmin;
    coord_t xmax;
    coord_t ymin;
    coord_t ymax;
  } rect_t;

  typedef struct packed {
    rect_t                a;
    rect_t                ov;
    logic [NUM_PARTS-1:0] parts;
    logic                 pass;
  } job_t;

endpackage

### design/rectangle_difference_unit.sv
// Rectangle difference unit: emits the pieces of rectangle A minus rectangle B.
// Items pass through the front stage register, the queue and the output register.
// The back end emits one piece per cycle while the output is not stalled; a fully
// covered item emits none, and the front takes an item every cycle the queue has room.
// Reset is synchronous and empties the front stage, the queue and the output register.
// Depends on rd_pkg, rd_front, rd_queue and rd_back.
module rectangle_difference_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rd_pkg::coord_t a_xmin,
  input  rd_pkg::coord_t a_xmax,
  input  rd_pkg::coord_t a_ymin,
  input  rd_pkg::coord_t a_ymax,
  input  rd_pkg::coord_t b_xmin,
  input  rd_pkg::coord_t b_xmax,
  input  rd_pkg::coord_t b_ymin,
  input  rd_pkg::coord_t b_ymax,
  output logic           out_valid,
  input  logic           out_ready,
  output rd_pkg::coord_t piece_xmin,
  output rd_pkg::coord_t piece_xmax,
  output rd_pkg::coord_t piece_ymin,
  output rd_pkg::coord_t piece_ymax,
  output logic           piece_last
);
  import rd_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;
  logic q_valid;
  logic q_pop;
  job_t q_job;

  rd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_xmin    (a_xmin),
    .a_xmax    (a_xmax),
    .a_ymin    (a_ymin),
    .a_ymax    (a_ymax),
    .b_xmin    (b_xmin),
    .b_xmax    (b_xmax),
    .b_ymin    (b_ymin),
    .b_ymax    (b_ymax),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  rd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (job_valid),
    .wr_ready (job_ready),
    .wr_job   (job),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_job   (q_job)
  );

  rd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .piece_xmin (piece_xmin),
    .piece_xmax (piece_xmax),
    .piece_ymin (piece_ymin),
    .piece_ymax (piece_ymax),
    .piece_last (piece_last)
  );

endmodule

### design/rd_front.sv
// Front end of the rectangle difference unit: accepts items and classifies them.
// Computes the overlap, the empty test and which pieces exist, into one register stage.
// Depends on rd_pkg.
module rd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rd_pkg::coord_t a_xmin,
  input  rd_pkg::coord_t a_xmax,
  input  rd_pkg::coord_t a_ymin,
  input  rd_pkg::coord_t a_ymax,
  input  rd_pkg::coord_t b_xmin,
  input  rd_pkg::coord_t b_xmax,
  input  rd_pkg::coord_t b_ymin,
  input  rd_pkg::coord_t b_ymax,
  output logic           job_valid,
  input  logic           job_ready,
  output rd_pkg::job_t   job
);
  import rd_pkg::*;

  job_t job_next;
  logic stage_valid;

  always_comb begin
    job_next.a.xmin  = a_xmin;
    job_next.a.xmax  = a_xmax;
    job_next.a.ymin  = a_ymin;
    job_next.a.ymax  = a_ymax;
    job_next.ov.xmin = (a_xmin > b_xmin) ? a_xmin : b_xmin;
    job_next.ov.xmax = (a_xmax < b_xmax) ? a_xmax : b_xmax;
    job_next.ov.ymin = (a_ymin > b_ymin) ? a_ymin : b_ymin;
    job_next.ov.ymax = (a_ymax < b_ymax) ? a_ymax : b_ymax;
    job_next.pass    = (job_next.ov.xmin >= job_next.ov.xmax) ||
                       (job_next.ov.ymin >= job_next.ov.ymax);
    job_next.parts[PART_LEFT]   = b_xmin > a_xmin;
    job_next.parts[PART_RIGHT]  = b_xmax < a_xmax;
    job_next.parts[PART_BOTTOM] = b_ymin > a_ymin;
    job_next.parts[PART_TOP]    = b_ymax < a_ymax;
  end

  assign in_ready  = !stage_valid || job_ready;
  assign job_valid = stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job <= job_next;
    end
  end

endmodule

### design/rd_queue.sv
// Short job queue between the front and back of the rectangle difference unit.
// A small register array with read and write pointers and an occupancy count.
// Depends on rd_pkg.
module rd_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  rd_pkg::job_t wr_job,
  output logic         rd_valid,
  input  logic         rd_pop,
  output rd_pkg::job_t rd_job
);
  import rd_pkg::*;

  job_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 pop;

  assign wr_ready = count != QCNT_BITS'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_BITS'(1))
    else $error("queue count did not rise on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - QCNT_BITS'(1))
    else $error("queue count did not fall on pop");

endmodule

### design/rd_back.sv
// Back end of the rectangle difference unit: emits the pieces of the queued job.
// Walks the piece mask one piece per unstalled cycle into a registered output.
// Depends on rd_pkg.
module rd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  rd_pkg::job_t   q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output rd_pkg::coord_t piece_xmin,
  output rd_pkg::coord_t piece_xmax,
  output rd_pkg::coord_t piece_ymin,
  output rd_pkg::coord_t piece_ymax,
  output logic           piece_last
);
  import rd_pkg::*;

  logic [NUM_PARTS-1:0] done;
  logic [NUM_PARTS-1:0] done_next;
  logic [NUM_PARTS-1:0] rem;
  logic [NUM_PARTS-1:0] sel;
  logic                 can_load;
  logic                 load;
  rect_t                piece_next;
  logic                 last_next;

  assign rem      = q_job.parts & ~done;
  assign can_load = !out_valid || out_ready;

  always_comb begin
    sel = '0;
    if (rem[PART_LEFT]) begin
      sel[PART_LEFT] = 1'b1;
    end else if (rem[PART_RIGHT]) begin
      sel[PART_RIGHT] = 1'b1;
    end else if (rem[PART_BOTTOM]) begin
      sel[PART_BOTTOM] = 1'b1;
    end else if (rem[PART_TOP]) begin
      sel[PART_TOP] = 1'b1;
    end
  end

  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    done_next  = done;
    piece_next = q_job.a;
    last_next  = (rem & ~sel) == '0;
    if (sel[PART_LEFT]) begin
      piece_next.xmax = q_job.ov.xmin;
    end else if (sel[PART_RIGHT]) begin
      piece_next.xmin = q_job.ov.xmax;
    end else if (sel[PART_BOTTOM]) begin
      piece_next.xmin = q_job.ov.xmin;
      piece_next.xmax = q_job.ov.xmax;
      piece_next.ymax = q_job.ov.ymin;
    end else if (sel[PART_TOP]) begin
      piece_next.xmin = q_job.ov.xmin;
      piece_next.xmax = q_job.ov.xmax;
      piece_next.ymin = q_job.ov.ymax;
    end
    if (q_valid) begin
      if (q_job.pass) begin
        piece_next = q_job.a;
        last_next  = 1'b1;
        if (can_load) begin
          load  = 1'b1;
          q_pop = 1'b1;
        end
      end else if (rem == '0) begin
        q_pop     = 1'b1;
        done_next = '0;
      end else if (can_load) begin
        load = 1'b1;
        if (last_next) begin
          q_pop     = 1'b1;
          done_next = '0;
        end else begin
          done_next = done | sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      done <= done_next;
      if (can_load) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      piece_xmin <= piece_next.xmin;
      piece_xmax <= piece_next.xmax;
      piece_ymin <= piece_next.ymin;
      piece_ymax <= piece_next.ymax;
      piece_last <= last_next;
    end
  end

  a_done_needs_job: assert property (@(posedge clk) disable iff (rst)
    (done != '0) |-> q_valid)
    else $error("pieces marked done with no job at the queue head");

  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_job.pass) |-> done == '0)
    else $error("pass-through job has pieces marked done");

  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (done & ~q_job.parts) == '0)
    else $error("done mask holds a piece the job does not have");

  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> done == '0)
    else $error("done mask not cleared after a job is retired");

endmodule

### test/rectangle_difference_checker.sv
// Checker for the rectangle difference unit: watches both channels, predicts the pieces
// of every accepted item and compares each emitted piece, field by field, with the oldest.
// Depends on rd_pkg.
module rectangle_difference_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  rd_pkg::coord_t a_xmin,
  input  rd_pkg::coord_t a_xmax,
  input  rd_pkg::coord_t a_ymin,
  input  rd_pkg::coord_t a_ymax,
  input  rd_pkg::coord_t b_xmin,
  input  rd_pkg::coord_t b_xmax,
  input  rd_pkg::coord_t b_ymin,
  input  rd_pkg::coord_t b_ymax,
  input  logic           out_valid,
  input  logic           out_ready,
  input  rd_pkg::coord_t piece_xmin,
  input  rd_pkg::coord_t piece_xmax,
  input  rd_pkg::coord_t piece_ymin,
  input  rd_pkg::coord_t piece_ymax,
  input  logic           piece_last,
  output int             mismatch_total,
  output int             pieces_pending
);

  typedef struct packed {
    rd_pkg::rect_t r;
    logic          last;
  } piece_t;

  piece_t expected_pieces[$];
  int     mismatch_count = 0;
  int     pending_count  = 0;

  assign mismatch_total = mismatch_count;
  assign pieces_pending = pending_count;

  function automatic piece_t make_piece(rd_pkg::coord_t x0, rd_pkg::coord_t x1,
                                        rd_pkg::coord_t y0, rd_pkg::coord_t y1);
    piece_t p;
    p.r.xmin = x0;
    p.r.xmax = x1;
    p.r.ymin = y0;
    p.r.ymax = y1;
    p.last   = 1'b0;
    return p;
  endfunction

  function automatic void add_piece(piece_t p);
    expected_pieces = {expected_pieces, p};
  endfunction

  function automatic void predict_pieces(rd_pkg::rect_t a, rd_pkg::rect_t b);
    rd_pkg::coord_t ox0, ox1, oy0, oy1;
    piece_t         whole;
    int             first;
    first = expected_pieces.size();
    ox0 = ($signed(a.xmin) > $signed(b.xmin)) ? a.xmin : b.xmin;
    ox1 = ($signed(a.xmax) < $signed(b.xmax)) ? a.xmax : b.xmax;
    oy0 = ($signed(a.ymin) > $signed(b.ymin)) ? a.ymin : b.ymin;
    oy1 = ($signed(a.ymax) < $signed(b.ymax)) ? a.ymax : b.ymax;
    if (ox0 >= ox1 || oy0 >= oy1) begin
      whole      = make_piece(a.xmin, a.xmax, a.ymin, a.ymax);
      whole.last = 1'b1;
      add_piece(whole);
    end else begin
      if (ox0 > $signed(a.xmin))
        add_piece(make_piece(a.xmin, ox0, a.ymin, a.ymax));
      if (ox1 < $signed(a.xmax))
        add_piece(make_piece(ox1, a.xmax, a.ymin, a.ymax));
      if (oy0 > $signed(a.ymin))
        add_piece(make_piece(ox0, ox1, a.ymin, oy0));
      if (oy1 < $signed(a.ymax))
        add_piece(make_piece(ox0, ox1, oy1, a.ymax));
      if (expected_pieces.size() > first)
        expected_pieces[expected_pieces.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic check_field(string name, rd_pkg::coord_t want, rd_pkg::coord_t got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    piece_t        want;
    rd_pkg::rect_t ra, rb;
    if (!rst) begin
      if (in_valid && in_ready) begin
        ra = '{a_xmin, a_xmax, a_ymin, a_ymax};
        rb = '{b_xmin, b_xmax, b_ymin, b_ymax};
        predict_pieces(ra, rb);
      end
      if (out_valid && out_ready) begin
        if (expected_pieces.size() == 0) begin
          mismatch_count++;
          $display("%0t: piece expected none got %0d %0d %0d %0d last %0b", $time,
                   piece_xmin, piece_xmax, piece_ymin, piece_ymax, piece_last);
        end else begin
          want = expected_pieces.pop_front();
          check_field("piece_xmin", want.r.xmin, piece_xmin);
          check_field("piece_xmax", want.r.xmax, piece_xmax);
          check_field("piece_ymin", want.r.ymin, piece_ymin);
          check_field("piece_ymax", want.r.ymax, piece_ymax);
          check_field("piece_last", {31'd0, want.last}, {31'd0, piece_last});
        end
      end
      pending_count = expected_pieces.size();
    end
  end

endmodule

### test/rectangle_difference_unit_test.sv
// Top of the rectangle difference unit testbench: clock, reset, stimulus and verdict.
// Drives directed and random rectangle pairs with random idling on both channels.
// Depends on rd_pkg, rectangle_difference_unit and rectangle_difference_checker.
module rectangle_difference_unit_test;

  localparam int RANDOM_PAIRS = 390;
  localparam int CALM_FROM    = 330;
  localparam int LONG_HOLD    = 300;

  localparam rd_pkg::coord_t MOST_NEG = {1'b1, {(rd_pkg::COORD_BITS-1){1'b0}}};
  localparam rd_pkg::coord_t MOST_POS = {1'b0, {(rd_pkg::COORD_BITS-1){1'b1}}};
  localparam logic [31:0]    SIGN_BIT = 32'h8000_0000;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  rd_pkg::coord_t a_xmin, a_xmax, a_ymin, a_ymax;
  rd_pkg::coord_t b_xmin, b_xmax, b_ymin, b_ymax;
  logic           out_valid;
  logic           out_ready;
  rd_pkg::coord_t piece_xmin, piece_xmax, piece_ymin, piece_ymax;
  logic           piece_last;
  int             mismatch_total;
  int             pieces_pending;

  int   pairs_taken = 0;
  logic calm        = 1'b0;
  logic held_long   = 1'b0;

  rectangle_difference_unit dut (.*);

  rectangle_difference_checker checker_inst (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic rd_pkg::rect_t box(rd_pkg::coord_t x0, rd_pkg::coord_t x1,
                                        rd_pkg::coord_t y0, rd_pkg::coord_t y1);
    rd_pkg::rect_t r;
    r.xmin = x0;
    r.xmax = x1;
    r.ymin = y0;
    r.ymax = y1;
    return r;
  endfunction

  // Coordinates are built in offset binary from a common base so that the pairs stay
  // ordered near the ends of the range as well as around zero.
  function automatic rd_pkg::rect_t cluster_box(logic [31:0] base, int spread, int span);
    logic [31:0] x0, y0;
    x0 = base + $urandom_range(spread, 0);
    y0 = base + $urandom_range(spread, 0);
    return box(x0 ^ SIGN_BIT, (x0 + $urandom_range(span, 0)) ^ SIGN_BIT,
               y0 ^ SIGN_BIT, (y0 + $urandom_range(span, 0)) ^ SIGN_BIT);
  endfunction

  function automatic rd_pkg::rect_t noise_box();
    return box($urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_pair(rd_pkg::rect_t a, rd_pkg::rect_t b);
    int gap;
    @(negedge clk);
    a_xmin   <= a.xmin;
    a_xmax   <= a.xmax;
    a_ymin   <= a.ymin;
    a_ymax   <= a.ymax;
    b_xmin   <= b.xmin;
    b_xmax   <= b.xmax;
    b_ymin   <= b.ymin;
    b_ymax   <= b.ymax;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pairs_taken++;
    if (!calm && $urandom_range(4, 0) == 0) begin
      gap = $urandom_range(17, 1);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held_long && pairs_taken >= 40) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held_long = 1'b1;
      end else if (!calm && $urandom_range(5, 0) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(17, 1) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0]   base;
    rd_pkg::rect_t a, b;
    int            waited;
    rst      = 1'b1;
    in_valid = 1'b0;
    a_xmin   = '0;
    a_xmax   = '0;
    a_ymin   = '0;
    a_ymax   = '0;
    b_xmin   = '0;
    b_xmax   = '0;
    b_ymin   = '0;
    b_ymax   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_pair(box(0, 10, 0, 10), box(2, 5, 3, 7));
    send_pair(box(0, 10, 0, 10), box(10, 20, 0, 10));
    send_pair(box(0, 10, 0, 10), box(0, 10, -5, 0));
    send_pair(box(0, 10, 0, 10), box(-1, 11, -1, 11));
    send_pair(box(0, 10, 0, 10), box(0, 10, 0, 10));
    send_pair(box(5, 5, 0, 10), box(0, 10, 0, 10));
    send_pair(box(10, 0, 0, 10), box(-100, 100, -100, 100));
    send_pair(box(0, 10, 0, 10), box(5, 20, -5, 15));
    send_pair(box(0, 10, 0, 10), box(-5, 5, -5, 15));
    send_pair(box(0, 10, 0, 10), box(-5, 15, 5, 15));
    send_pair(box(0, 10, 0, 10), box(-5, 15, -5, 5));
    send_pair(box(0, 10, 0, 10), box(3, 7, -5, 15));
    send_pair(box(0, 10, 0, 10), box(-5, 15, 3, 7));
    send_pair(box(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS), box(0, 1, 0, 1));
    send_pair(box(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS),
              box(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS));
    send_pair(box(MOST_POS, MOST_NEG, MOST_POS, MOST_NEG),
              box(MOST_POS, MOST_NEG, MOST_POS, MOST_NEG));
    send_pair(box(-1, 0, -1, 0), box(MOST_NEG, 0, MOST_NEG, 0));
    send_pair(box(0, 0, 0, 0), box(0, 0, 0, 0));
    send_pair(box(-1, -1, -1, -1), box(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS));
    send_pair(box(-10, 10, -10, 10), box(-3, 3, MOST_NEG, 0));
    send_pair(box(MOST_NEG, MOST_NEG + 1, MOST_NEG, MOST_NEG + 1),
              box(MOST_POS - 1, MOST_POS, MOST_POS - 1, MOST_POS));
    send_pair(box(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS),
              box(MOST_NEG + 1, MOST_POS - 1, MOST_NEG + 1, MOST_POS - 1));

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i >= CALM_FROM)
        calm = 1'b1;
      case ($urandom_range(3, 0))
        0: base = '0;
        1: base = 32'hFFFF_FFD0;
        2: base = 32'h7FFF_FFF0;
        default: base = $urandom_range(32'hFFFF_FFD0, 0);
      endcase
      case ($urandom_range(9, 0))
        0, 1: begin
          a = noise_box();
          b = noise_box();
        end
        2: begin
          a = cluster_box(base, 7, 8);
          b = noise_box();
        end
        default: begin
          a = cluster_box(base, 7, 8);
          b = cluster_box(base, 15, 10);
        end
      endcase
      send_pair(a, b);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (pieces_pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (mismatch_total == 0 && pieces_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
